// ===== rtl/cfsp_pkg.sv =====
`default_nettype none
package cfsp_pkg;

   typedef enum logic [4:0] {
      PH_MAGIC    = 5'd0,
      PH_MINOR    = 5'd1,
      PH_MAJOR    = 5'd2,
      PH_POOLCNT  = 5'd3,
      PH_TAG      = 5'd4,
      PH_OP1      = 5'd5,
      PH_OP2      = 5'd6,
      PH_UTFLEN   = 5'd7,
      PH_UTFBYTE  = 5'd8,
      PH_MHKIND   = 5'd9,
      PH_VAL4     = 5'd10,
      PH_VAL8     = 5'd11,
      PH_FLAGS    = 5'd12,
      PH_THIS     = 5'd13,
      PH_SUPER    = 5'd14,
      PH_IFCNT    = 5'd15,
      PH_IFACE    = 5'd16,
      PH_FIELDCNT = 5'd17,
      PH_MFLAGS   = 5'd18,
      PH_MNAME    = 5'd19,
      PH_MDESC    = 5'd20,
      PH_MATTRCNT = 5'd21,
      PH_ANAME    = 5'd22,
      PH_ALEN     = 5'd23,
      PH_ABYTE    = 5'd24,
      PH_METHCNT  = 5'd25,
      PH_CATTRCNT = 5'd26
   } phase_type;

   typedef enum logic [1:0] {
      ST_ACTIVE = 2'd0,
      ST_DONE   = 2'd1,
      ST_EARLY  = 2'd2,
      ST_BADTAG = 2'd3
   } status_type;

   localparam logic [2:0] SEC_HEADER = 3'd0;
   localparam logic [2:0] SEC_POOL   = 3'd1;
   localparam logic [2:0] SEC_CLASS  = 3'd2;
   localparam logic [2:0] SEC_IFACE  = 3'd3;
   localparam logic [2:0] SEC_FIELDS = 3'd4;
   localparam logic [2:0] SEC_METHS  = 3'd5;
   localparam logic [2:0] SEC_CATTR  = 3'd6;

   localparam logic [4:0] KIND_EARLY = 5'd21;

   typedef struct packed {
      logic [2:0]  section;
      logic [4:0]  kind;
      logic [63:0] value;
      logic [15:0] entry_index;
      logic [15:0] sub_index;
      logic [1:0]  status;
   } rsp_type;

   // bytes in the field of each phase
   function automatic logic [3:0] phase_width(input phase_type ph);
      logic [3:0] w;
      case (ph)
         PH_MAGIC, PH_VAL4, PH_ALEN:        w = 4'd4;
         PH_TAG, PH_UTFBYTE, PH_MHKIND,
         PH_ABYTE:                          w = 4'd1;
         PH_VAL8:                           w = 4'd8;
         default:                           w = 4'd2;
      endcase
      return w;
   endfunction

   // result kind of each phase
   function automatic logic [4:0] phase_kind(input phase_type ph);
      logic [4:0] k;
      case (ph)
         PH_MAGIC:    k = 5'd0;
         PH_MINOR:    k = 5'd1;
         PH_MAJOR:    k = 5'd2;
         PH_POOLCNT, PH_IFCNT, PH_FIELDCNT,
         PH_METHCNT, PH_CATTRCNT: k = 5'd3;
         PH_TAG:      k = 5'd4;
         PH_OP1:      k = 5'd5;
         PH_OP2:      k = 5'd6;
         PH_UTFLEN:   k = 5'd9;
         PH_UTFBYTE, PH_ABYTE: k = 5'd10;
         PH_MHKIND:   k = 5'd11;
         PH_VAL4:     k = 5'd7;
         PH_VAL8:     k = 5'd8;
         PH_FLAGS, PH_MFLAGS: k = 5'd12;
         PH_THIS:     k = 5'd13;
         PH_SUPER:    k = 5'd14;
         PH_IFACE:    k = 5'd15;
         PH_MNAME:    k = 5'd16;
         PH_MDESC:    k = 5'd17;
         PH_MATTRCNT: k = 5'd18;
         PH_ANAME:    k = 5'd19;
         PH_ALEN:     k = 5'd20;
         default:     k = KIND_EARLY;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/cfsp_walker.sv =====
`default_nettype none
// Parse state and per-byte result formation; one byte per cycle while step is high.
module cfsp_walker (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  step,
   input  wire  [7:0]           byte_value,
   input  wire                  end_of_data,
   output logic                 have,
   output logic [1:0]           fin_pre,
   output cfsp_pkg::rsp_type    rsp
);
   import cfsp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [15:0] pool_size_ff, pool_size_in, pool_slot_ff, pool_slot_in;
   logic [15:0] list_size_ff, list_size_in, list_pos_ff, list_pos_in;
   logic [15:0] attr_tot_ff, attr_tot_in, attr_pos_ff, attr_pos_in;
   logic [31:0] left_ff, left_in;
   logic [4:0]  tag_ff, tag_in;
   logic [1:0]  fin_ff, fin_in;
   logic [2:0]  sect_ff, sect_in;
   logic [15:0] ppos_ff, ppos_in;

   logic [63:0] val;
   logic        done;
   logic [15:0] v16;
   logic [7:0]  t;
   logic        two_ops;
   logic [16:0] pool_next;
   logic        pool_step2;
   logic        pool_go;
   logic        attr_go;
   logic        member_go;
   logic [15:0] attr_pos_nx;
   logic [15:0] list_pos_nx;
   logic [31:0] left_dec;
   logic [15:0] ent, sub;

   always_comb begin
      val  = (cnt_ff == 3'd0) ? {56'd0, byte_value} : {acc_ff[55:0], byte_value};
      done = ({1'b0, cnt_ff} + 4'd1) >= phase_width(phase_ff);
      v16  = val[15:0];
      t    = val[7:0];
      two_ops = (tag_ff == 5'd9) || (tag_ff == 5'd10) || (tag_ff == 5'd11) ||
                (tag_ff == 5'd12) || (tag_ff == 5'd17) || (tag_ff == 5'd18);
      left_dec = left_ff - 32'd1;
   end

   // next-state logic
   always_comb begin
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      pool_size_in = pool_size_ff;
      pool_slot_in = pool_slot_ff;
      list_size_in = list_size_ff;
      list_pos_in  = list_pos_ff;
      attr_tot_in  = attr_tot_ff;
      attr_pos_in  = attr_pos_ff;
      left_in      = left_ff;
      tag_in       = tag_ff;
      fin_in       = fin_ff;
      sect_in      = sect_ff;
      ppos_in      = ppos_ff;
      pool_go      = 1'b0;
      pool_step2   = 1'b0;
      attr_go      = 1'b0;
      member_go    = 1'b0;
      attr_pos_nx  = attr_pos_ff;
      list_pos_nx  = list_pos_ff;
      pool_next    = 17'd0;
      if (fin_ff == 2'd0) begin
         acc_in = val;
         cnt_in = cnt_ff + 3'd1;
         if (done) begin
            cnt_in = 3'd0;
            case (phase_ff)
               PH_MAGIC: phase_in = PH_MINOR;
               PH_MINOR: phase_in = PH_MAJOR;
               PH_MAJOR: begin
                  sect_in = SEC_POOL;
                  phase_in = PH_POOLCNT;
               end
               PH_POOLCNT: begin
                  pool_size_in = v16;
                  pool_slot_in = 16'd0;
                  pool_go = 1'b1;
               end
               PH_TAG: begin
                  tag_in = t[4:0];
                  if (t == 8'd7 || t == 8'd8 || t == 8'd16 || t == 8'd19 ||
                      t == 8'd20 || t == 8'd9 || t == 8'd10 || t == 8'd11 ||
                      t == 8'd12 || t == 8'd17 || t == 8'd18)
                     phase_in = PH_OP1;
                  else if (t == 8'd3 || t == 8'd4) phase_in = PH_VAL4;
                  else if (t == 8'd5 || t == 8'd6) phase_in = PH_VAL8;
                  else if (t == 8'd1) phase_in = PH_UTFLEN;
                  else if (t == 8'd15) phase_in = PH_MHKIND;
                  else fin_in = 2'd2;
               end
               PH_OP1: begin
                  if (two_ops) phase_in = PH_OP2;
                  else pool_go = 1'b1;
               end
               PH_OP2: pool_go = 1'b1;
               PH_UTFLEN: begin
                  left_in = {16'd0, v16};
                  ppos_in = 16'd0;
                  if (v16 == 16'd0) pool_go = 1'b1;
                  else phase_in = PH_UTFBYTE;
               end
               PH_UTFBYTE: begin
                  ppos_in = ppos_ff + 16'd1;
                  left_in = left_dec;
                  if (left_dec == 32'd0) pool_go = 1'b1;
               end
               PH_MHKIND: phase_in = PH_OP1;
               PH_VAL4: pool_go = 1'b1;
               PH_VAL8: begin
                  pool_go = 1'b1;
                  pool_step2 = 1'b1;
               end
               PH_FLAGS: phase_in = PH_THIS;
               PH_THIS:  phase_in = PH_SUPER;
               PH_SUPER: begin
                  sect_in = SEC_IFACE;
                  phase_in = PH_IFCNT;
               end
               PH_IFCNT: begin
                  list_size_in = v16;
                  list_pos_in = 16'd0;
                  if (v16 == 16'd0) begin
                     sect_in = SEC_FIELDS;
                     phase_in = PH_FIELDCNT;
                  end else begin
                     phase_in = PH_IFACE;
                  end
               end
               PH_IFACE: begin
                  list_pos_in = list_pos_ff + 16'd1;
                  if (list_pos_in >= list_size_ff) begin
                     sect_in = SEC_FIELDS;
                     phase_in = PH_FIELDCNT;
                  end
               end
               PH_FIELDCNT, PH_METHCNT: begin
                  list_size_in = v16;
                  list_pos_in = 16'd0;
                  list_pos_nx = 16'd0;
                  member_go = 1'b1;
               end
               PH_MFLAGS: phase_in = PH_MNAME;
               PH_MNAME:  phase_in = PH_MDESC;
               PH_MDESC:  phase_in = PH_MATTRCNT;
               PH_MATTRCNT, PH_CATTRCNT: begin
                  attr_tot_in = v16;
                  attr_pos_in = 16'd0;
                  attr_pos_nx = 16'd0;
                  attr_go = 1'b1;
               end
               PH_ANAME: phase_in = PH_ALEN;
               PH_ALEN: begin
                  left_in = val[31:0];
                  ppos_in = 16'd0;
                  if (val[31:0] == 32'd0) begin
                     attr_pos_nx = attr_pos_ff + 16'd1;
                     attr_pos_in = attr_pos_nx;
                     attr_go = 1'b1;
                  end else begin
                     phase_in = PH_ABYTE;
                  end
               end
               PH_ABYTE: begin
                  ppos_in = ppos_ff + 16'd1;
                  left_in = left_dec;
                  if (left_dec == 32'd0) begin
                     attr_pos_nx = attr_pos_ff + 16'd1;
                     attr_pos_in = attr_pos_nx;
                     attr_go = 1'b1;
                  end
               end
               default: fin_in = 2'd2;
            endcase

            // pool slot advance
            if (pool_go) begin
               pool_next = {1'b0, pool_slot_in} + (pool_step2 ? 17'd2 : 17'd1);
               pool_slot_in = pool_next[15:0];
               if (pool_next < {1'b0, pool_size_in}) begin
                  phase_in = PH_TAG;
               end else begin
                  sect_in = SEC_CLASS;
                  phase_in = PH_FLAGS;
               end
            end

            // attribute list advance
            if (attr_go) begin
               if (attr_pos_nx < attr_tot_in) begin
                  phase_in = PH_ANAME;
               end else if (sect_ff == SEC_CATTR) begin
                  fin_in = 2'd1;
               end else begin
                  list_pos_nx = list_pos_ff + 16'd1;
                  list_pos_in = list_pos_nx;
                  member_go = 1'b1;
               end
            end

            // member list advance
            if (member_go) begin
               if (list_pos_nx < list_size_in) begin
                  phase_in = PH_MFLAGS;
               end else if (sect_ff == SEC_FIELDS) begin
                  sect_in = SEC_METHS;
                  phase_in = PH_METHCNT;
               end else begin
                  sect_in = SEC_CATTR;
                  phase_in = PH_CATTRCNT;
               end
            end
         end
      end
      // finish code of this byte, before any rearm
      fin_pre = fin_in;
      // last byte rearms the parser
      if (end_of_data) begin
         phase_in = PH_MAGIC;
         cnt_in = 3'd0;
         acc_in = 64'd0;
         pool_size_in = 16'd0;
         pool_slot_in = 16'd0;
         list_size_in = 16'd0;
         list_pos_in = 16'd0;
         attr_tot_in = 16'd0;
         attr_pos_in = 16'd0;
         left_in = 32'd0;
         tag_in = 5'd0;
         fin_in = 2'd0;
         sect_in = SEC_HEADER;
         ppos_in = 16'd0;
      end
   end

   // result formation
   always_comb begin
      ent = 16'd0;
      sub = 16'd0;
      if (phase_ff >= PH_TAG && phase_ff <= PH_VAL8) begin
         ent = pool_slot_ff;
         if (phase_ff == PH_UTFBYTE) sub = ppos_ff;
      end else if (phase_ff == PH_IFACE ||
                   (phase_ff >= PH_MFLAGS && phase_ff <= PH_MATTRCNT)) begin
         ent = list_pos_ff;
      end else if (phase_ff >= PH_ANAME && phase_ff <= PH_ABYTE) begin
         if (sect_ff == SEC_CATTR) begin
            ent = attr_pos_ff;
            sub = (phase_ff == PH_ABYTE) ? ppos_ff : 16'd0;
         end else begin
            ent = list_pos_ff;
            sub = (phase_ff == PH_ABYTE) ? ppos_ff : attr_pos_ff;
         end
      end
      have = (fin_ff == 2'd0) && (done || end_of_data);
      rsp.section = sect_ff;
      rsp.kind = done ? phase_kind(phase_ff) : KIND_EARLY;
      rsp.value = done ? val : 64'd0;
      rsp.entry_index = done ? ent : 16'd0;
      rsp.sub_index = done ? sub : 16'd0;
      // status is set at the top level from the finish code
      rsp.status = ST_ACTIVE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_MAGIC;
         cnt_ff       <= 3'd0;
         acc_ff       <= 64'd0;
         pool_size_ff <= 16'd0;
         pool_slot_ff <= 16'd0;
         list_size_ff <= 16'd0;
         list_pos_ff  <= 16'd0;
         attr_tot_ff  <= 16'd0;
         attr_pos_ff  <= 16'd0;
         left_ff      <= 32'd0;
         tag_ff       <= 5'd0;
         fin_ff       <= 2'd0;
         sect_ff      <= SEC_HEADER;
         ppos_ff      <= 16'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         pool_size_ff <= pool_size_in;
         pool_slot_ff <= pool_slot_in;
         list_size_ff <= list_size_in;
         list_pos_ff  <= list_pos_in;
         attr_tot_ff  <= attr_tot_in;
         attr_pos_ff  <= attr_pos_in;
         left_ff      <= left_in;
         tag_ff       <= tag_in;
         fin_ff       <= fin_in;
         sect_ff      <= sect_in;
         ppos_ff      <= ppos_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/cfsp_status.sv =====
`default_nettype none
// Status code of a result from the finish code before rearm.
module cfsp_status (
   input  wire         bad_tag,
   input  wire         complete,
   input  wire         end_of_data,
   output logic [1:0]  status
);
   import cfsp_pkg::*;

   always_comb begin
      if (bad_tag)          status = ST_BADTAG;
      else if (complete)    status = ST_DONE;
      else if (end_of_data) status = ST_EARLY;
      else                  status = ST_ACTIVE;
   end
endmodule
`default_nettype wire

// ===== rtl/class_file_structure_parser_core.sv =====
`default_nettype none
// A result word is registered into the result buffer when its byte is accepted.
// Throughput: one byte per cycle while req_stall is low; the parse state updates in a single pass.
// A two-entry buffer on the result side absorbs output stall; input stalls while it is full.
// Reset (synchronous, active high) returns the parser to the magic number
// and empties the result buffer.
module class_file_structure_parser_core (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_stall,
   input  wire  [7:0]   req_byte_value,
   input  wire          req_end_of_data,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output logic [2:0]   rsp_section,
   output logic [4:0]   rsp_kind,
   output logic [63:0]  rsp_value,
   output logic [15:0]  rsp_entry_index,
   output logic [15:0]  rsp_sub_index,
   output logic [1:0]   rsp_status
);
   import cfsp_pkg::*;

   logic    step, have;
   rsp_type raw, word;
   logic [1:0] st;
   logic [1:0] fin_pre;

   rsp_type    q0_ff, q0_in, q1_ff, q1_in;
   logic [1:0] n_ff, n_in;
   logic       push, pop;

   assign req_stall = (n_ff == 2'd2);
   assign step = req_valid && !req_stall;

   cfsp_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .byte_value (req_byte_value),
      .end_of_data(req_end_of_data),
      .have       (have),
      .fin_pre    (fin_pre),
      .rsp        (raw)
   );

   cfsp_status u_status (
      .bad_tag    (fin_pre == 2'd2),
      .complete   (fin_pre == 2'd1),
      .end_of_data(req_end_of_data),
      .status     (st)
   );

   always_comb begin
      word = raw;
      word.status = st;
   end

   // result queue
   assign push = step && have;
   assign pop  = rsp_valid && !rsp_stall;
   always_comb begin
      n_in = n_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= 2'd0;
      end else begin
         n_ff <= n_in;
      end
   end

   always_comb begin
      q0_in = q0_ff;
      q1_in = q1_ff;
      if (pop) begin
         q0_in = q1_ff;
      end
      if (push) begin
         if ((n_ff == 2'd0) || (n_ff == 2'd1 && pop)) q0_in = word;
         else q1_in = word;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign rsp_valid       = (n_ff != 2'd0);
   assign rsp_section     = q0_ff.section;
   assign rsp_kind        = q0_ff.kind;
   assign rsp_value       = q0_ff.value;
   assign rsp_entry_index = q0_ff.entry_index;
   assign rsp_sub_index   = q0_ff.sub_index;
   assign rsp_status      = q0_ff.status;
endmodule
`default_nettype wire

// ===== tb/sv/tb_class_file_structure_parser_core.sv =====
`timescale 1ns / 100ps
module tb_class_file_structure_parser_core;
   import cfsp_pkg::*;

   localparam int unsigned T_UTF8 = 1, T_INT = 3, T_FLOAT = 4, T_LONG = 5, T_DOUBLE = 6;
   localparam int unsigned T_CLASS = 7, T_STRING = 8, T_FIELDREF = 9, T_METHODREF = 10;
   localparam int unsigned T_IFMREF = 11, T_NAMETYPE = 12, T_MHANDLE = 15, T_MTYPE = 16;
   localparam int unsigned T_DYNAMIC = 17, T_INDY = 18, T_MODULE = 19, T_PACKAGE = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_value = 8'd0;
   logic        req_end_of_data = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_section;
   logic [4:0]  rsp_kind;
   logic [63:0] rsp_value;
   logic [15:0] rsp_entry_index;
   logic [15:0] rsp_sub_index;
   logic [1:0]  rsp_status;

   class_file_structure_parser_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_byte_value(req_byte_value), .req_end_of_data(req_end_of_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_section(rsp_section), .rsp_kind(rsp_kind), .rsp_value(rsp_value),
      .rsp_entry_index(rsp_entry_index), .rsp_sub_index(rsp_sub_index),
      .rsp_status(rsp_status)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // predicted parser state
   phase_type   ph;
   int unsigned nbytes;
   logic [63:0] acc;
   logic [15:0] pool_cnt, slot, lst_cnt, lst_pos, attr_cnt, attr_pos, pay_pos;
   logic [31:0] pay_left;
   logic [4:0]  tag_now;
   logic [1:0]  done_state;
   logic [2:0]  sec;

   rsp_type     expected_words[$];
   int          errors = 0;
   bit          idle_on = 1'b1;
   bit          hold_on = 1'b1;
   logic [7:0]  file_bytes[$];

   task automatic parser_clear();
      ph = PH_MAGIC; nbytes = 0; acc = '0; pool_cnt = '0; slot = '0;
      lst_cnt = '0; lst_pos = '0; attr_cnt = '0; attr_pos = '0;
      pay_left = '0; tag_now = '0; done_state = 2'd0; sec = SEC_HEADER; pay_pos = '0;
   endtask

   function automatic bit two_ops(input int unsigned t);
      return t == T_FIELDREF || t == T_METHODREF || t == T_IFMREF || t == T_NAMETYPE ||
             t == T_DYNAMIC || t == T_INDY;
   endfunction

   function automatic int unsigned width_now(input phase_type p);
      case (p)
         PH_MAGIC, PH_VAL4, PH_ALEN: return 4;
         PH_TAG, PH_UTFBYTE, PH_MHKIND, PH_ABYTE: return 1;
         PH_VAL8: return 8;
         default: return 2;
      endcase
   endfunction

   function automatic logic [4:0] kind_now(input phase_type p);
      case (p)
         PH_MAGIC: return 5'd0;
         PH_MINOR: return 5'd1;
         PH_MAJOR: return 5'd2;
         PH_POOLCNT, PH_IFCNT, PH_FIELDCNT, PH_METHCNT, PH_CATTRCNT: return 5'd3;
         PH_TAG: return 5'd4;
         PH_OP1: return 5'd5;
         PH_OP2: return 5'd6;
         PH_VAL4: return 5'd7;
         PH_VAL8: return 5'd8;
         PH_UTFLEN: return 5'd9;
         PH_UTFBYTE, PH_ABYTE: return 5'd10;
         PH_MHKIND: return 5'd11;
         PH_FLAGS, PH_MFLAGS: return 5'd12;
         PH_THIS: return 5'd13;
         PH_SUPER: return 5'd14;
         PH_IFACE: return 5'd15;
         PH_MNAME: return 5'd16;
         PH_MDESC: return 5'd17;
         PH_MATTRCNT: return 5'd18;
         PH_ANAME: return 5'd19;
         PH_ALEN: return 5'd20;
         default: return KIND_EARLY;
      endcase
   endfunction

   task automatic pool_step(input int unsigned n);
      int unsigned s;
      s = slot + n;
      slot = s[15:0];
      if (s < pool_cnt) ph = PH_TAG;
      else begin sec = SEC_CLASS; ph = PH_FLAGS; end
   endtask

   task automatic member_step();
      if (lst_pos < lst_cnt) ph = PH_MFLAGS;
      else if (sec == SEC_FIELDS) begin sec = SEC_METHS; ph = PH_METHCNT; end
      else begin sec = SEC_CATTR; ph = PH_CATTRCNT; end
   endtask

   task automatic attr_step();
      if (attr_pos < attr_cnt) ph = PH_ANAME;
      else if (sec == SEC_CATTR) done_state = 2'd1;
      else begin lst_pos = lst_pos + 16'd1; member_step(); end
   endtask

   task automatic field_done(input logic [63:0] v);
      int unsigned t;
      case (ph)
         PH_MAGIC: ph = PH_MINOR;
         PH_MINOR: ph = PH_MAJOR;
         PH_MAJOR: begin sec = SEC_POOL; ph = PH_POOLCNT; end
         PH_POOLCNT: begin pool_cnt = v[15:0]; slot = '0; pool_step(1); end
         PH_TAG: begin
            t = {24'd0, v[7:0]};
            tag_now = v[4:0];
            if (t == T_CLASS || t == T_STRING || t == T_MTYPE || t == T_MODULE ||
                t == T_PACKAGE || two_ops(t)) ph = PH_OP1;
            else if (t == T_INT || t == T_FLOAT) ph = PH_VAL4;
            else if (t == T_LONG || t == T_DOUBLE) ph = PH_VAL8;
            else if (t == T_UTF8) ph = PH_UTFLEN;
            else if (t == T_MHANDLE) ph = PH_MHKIND;
            else done_state = 2'd2;
         end
         PH_OP1: if (two_ops({27'd0, tag_now})) ph = PH_OP2; else pool_step(1);
         PH_OP2, PH_VAL4: pool_step(1);
         PH_VAL8: pool_step(2);
         PH_UTFLEN: begin
            pay_left = {16'd0, v[15:0]}; pay_pos = '0;
            if (pay_left == 0) pool_step(1); else ph = PH_UTFBYTE;
         end
         PH_UTFBYTE: begin
            pay_pos = pay_pos + 16'd1; pay_left = pay_left - 32'd1;
            if (pay_left == 0) pool_step(1);
         end
         PH_MHKIND: ph = PH_OP1;
         PH_FLAGS: ph = PH_THIS;
         PH_THIS: ph = PH_SUPER;
         PH_SUPER: begin sec = SEC_IFACE; ph = PH_IFCNT; end
         PH_IFCNT: begin
            lst_cnt = v[15:0]; lst_pos = '0;
            if (lst_cnt == 0) begin sec = SEC_FIELDS; ph = PH_FIELDCNT; end
            else ph = PH_IFACE;
         end
         PH_IFACE: begin
            lst_pos = lst_pos + 16'd1;
            if (lst_pos >= lst_cnt) begin sec = SEC_FIELDS; ph = PH_FIELDCNT; end
         end
         PH_FIELDCNT, PH_METHCNT: begin lst_cnt = v[15:0]; lst_pos = '0; member_step(); end
         PH_MFLAGS: ph = PH_MNAME;
         PH_MNAME: ph = PH_MDESC;
         PH_MDESC: ph = PH_MATTRCNT;
         PH_MATTRCNT, PH_CATTRCNT: begin attr_cnt = v[15:0]; attr_pos = '0; attr_step(); end
         PH_ANAME: ph = PH_ALEN;
         PH_ALEN: begin
            pay_left = v[31:0]; pay_pos = '0;
            if (pay_left == 0) begin attr_pos = attr_pos + 16'd1; attr_step(); end
            else ph = PH_ABYTE;
         end
         PH_ABYTE: begin
            pay_pos = pay_pos + 16'd1; pay_left = pay_left - 32'd1;
            if (pay_left == 0) begin attr_pos = attr_pos + 16'd1; attr_step(); end
         end
         default: done_state = 2'd2;
      endcase
   endtask

   // advance the predicted parser by one byte, queue any result word
   task automatic parse_byte(input logic [7:0] b, input bit last);
      rsp_type w;
      bit have;
      phase_type p;
      have = 1'b0;
      w = '0;
      if (done_state != 2'd0) begin
         if (last) parser_clear();
         return;
      end
      acc = (nbytes == 0) ? {56'd0, b} : {acc[55:0], b};
      nbytes++;
      if (nbytes >= width_now(ph)) begin
         p = ph;
         nbytes = 0;
         have = 1'b1;
         w.value = acc;
         w.section = sec;
         w.kind = kind_now(p);
         if (p >= PH_TAG && p <= PH_VAL8) begin
            w.entry_index = slot;
            if (p == PH_UTFBYTE) w.sub_index = pay_pos;
         end else if (p == PH_IFACE || (p >= PH_MFLAGS && p <= PH_MATTRCNT)) begin
            w.entry_index = lst_pos;
         end else if (p >= PH_ANAME && p <= PH_ABYTE) begin
            if (sec == SEC_CATTR) begin
               w.entry_index = attr_pos;
               w.sub_index = (p == PH_ABYTE) ? pay_pos : 16'd0;
            end else begin
               w.entry_index = lst_pos;
               w.sub_index = (p == PH_ABYTE) ? pay_pos : attr_pos;
            end
         end
         field_done(acc);
      end
      if (done_state == 2'd2) w.status = ST_BADTAG;
      else if (done_state == 2'd1) w.status = ST_DONE;
      else if (last) w.status = ST_EARLY;
      else w.status = ST_ACTIVE;
      if (last) begin
         if (!have) begin
            have = 1'b1;
            w.section = sec;
            w.kind = KIND_EARLY;
         end
         parser_clear();
      end
      if (have) expected_words.insert(expected_words.size(), w);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("word mismatch on %s: got %0h want %0h", what, got, want);
      errors++;
   endtask

   // send one byte over the request channel
   task automatic send_byte(input logic [7:0] b, input bit last);
      while (idle_on && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_byte_value <= b;
      req_end_of_data <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      parse_byte(b, last);
      @(negedge clock);
   endtask

   // result checker
   initial begin
      rsp_type w;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               report_mismatch("unexpected word", {59'd0, rsp_kind}, 64'd0);
            end else begin
               w = expected_words.pop_front();
               if (rsp_section !== w.section)
                  report_mismatch("section", {61'd0, rsp_section}, {61'd0, w.section});
               if (rsp_kind !== w.kind)
                  report_mismatch("kind", {59'd0, rsp_kind}, {59'd0, w.kind});
               if (rsp_value !== w.value) report_mismatch("value", rsp_value, w.value);
               if (rsp_entry_index !== w.entry_index)
                  report_mismatch("entry_index", {48'd0, rsp_entry_index},
                                  {48'd0, w.entry_index});
               if (rsp_sub_index !== w.sub_index)
                  report_mismatch("sub_index", {48'd0, rsp_sub_index}, {48'd0, w.sub_index});
               if (rsp_status !== w.status)
                  report_mismatch("status", {62'd0, rsp_status}, {62'd0, w.status});
            end
         end
      end
   end

   // receiver stall
   initial begin
      forever begin
         @(negedge clock);
         rsp_stall <= hold_on && ($urandom_range(99) < 23);
      end
   end

   // file building helpers
   task automatic put8(input logic [7:0] v);
      file_bytes.insert(file_bytes.size(), v);
   endtask

   task automatic put16(input int v);
      put8(v[15:8]); put8(v[7:0]);
   endtask

   task automatic put_rand(input int n);
      repeat (n) put8(8'($urandom_range(255)));
   endtask

   task automatic build_file(input int pool_n, input int ifc_n, input int fld_n,
                             input int meth_n, input int cattr_n);
      int s, t, n;
      file_bytes.delete();
      put8(8'hCA); put8(8'hFE);
      put8(8'hBA); put8(8'hBE);
      put_rand(4);
      put16(pool_n);
      s = 1;
      while (s < pool_n) begin
         case ($urandom_range(16))
            0: t = T_UTF8;   1: t = T_INT;      2: t = T_FLOAT;  3: t = T_LONG;
            4: t = T_DOUBLE; 5: t = T_CLASS;    6: t = T_STRING; 7: t = T_FIELDREF;
            8: t = T_METHODREF; 9: t = T_IFMREF; 10: t = T_NAMETYPE; 11: t = T_MHANDLE;
            12: t = T_MTYPE; 13: t = T_DYNAMIC; 14: t = T_INDY; 15: t = T_MODULE;
            default: t = T_PACKAGE;
         endcase
         put8(t[7:0]);
         if (t == T_UTF8) begin n = $urandom_range(3); put16(n); put_rand(n); end
         else if (t == T_INT || t == T_FLOAT) put_rand(4);
         else if (t == T_LONG || t == T_DOUBLE) begin put_rand(8); s++; end
         else if (t == T_MHANDLE) put_rand(3);
         else if (two_ops(t)) put_rand(4);
         else put_rand(2);
         s++;
      end
      put_rand(6);
      put16(ifc_n); put_rand(2 * ifc_n);
      for (int m = 0; m < 2; m++) begin
         put16(m == 0 ? fld_n : meth_n);
         repeat (m == 0 ? fld_n : meth_n) begin
            put_rand(6);
            n = $urandom_range(2); put16(n);
            repeat (n) begin
               t = $urandom_range(3);
               put_rand(2); put16(0); put16(t); put_rand(t);
            end
         end
      end
      put16(cattr_n);
      repeat (cattr_n) begin
         t = $urandom_range(4);
         put_rand(2); put16(0); put16(t); put_rand(t);
      end
   endtask

   // send the built file; cut = index of end-of-data byte, or past the end
   task automatic send_file(input int cut, input int trailing);
      int last_i;
      last_i = (cut < file_bytes.size()) ? cut : file_bytes.size() + trailing;
      for (int i = 0; i <= last_i; i++)
         send_byte(i < file_bytes.size() ? file_bytes[i] : 8'($urandom_range(255)),
                   i == last_i);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_extremes();
      build_file(3, 1, 1, 1, 1);
      file_bytes[8] = 8'hFF; file_bytes[9] = 8'hFF; // huge pool then early end
      send_file(9, 0);
      for (int i = 0; i < 4; i++) send_byte(i[0] ? 8'hFF : 8'h00, i == 3);
      send_byte(8'hFF, 1'b1); // early end on the first byte
      drain();
   endtask

   task automatic test_empty_structure();
      build_file(0, 0, 0, 0, 0);
      send_file(1 << 20, 2);
      build_file(1, 0, 0, 0, 0);
      send_file(1 << 20, 0);
      drain();
   endtask

   task automatic test_unknown_tag();
      build_file(2, 0, 0, 0, 0);
      file_bytes[10] = 8'd2;
      send_file(1 << 20, 3);
      build_file(2, 0, 0, 0, 0);
      file_bytes[10] = 8'd255;
      send_file(1 << 20, 0);
      drain();
   endtask

   task automatic test_wide_entries_last_slot();
      build_file(2, 0, 0, 0, 0);
      file_bytes[10] = 8'(T_LONG);
      file_bytes.insert(11, 8'h00); // keep stream shape plausible
      send_file(1 << 20, 1);
      drain();
   endtask

   task automatic test_random_files();
      int bytes_sent;
      bytes_sent = 0;
      while (bytes_sent < 1300) begin
         idle_on = (bytes_sent < 400 || bytes_sent > 700);
         hold_on = idle_on;
         build_file($urandom_range(6), $urandom_range(2), $urandom_range(2),
                    $urandom_range(2), $urandom_range(2));
         if ($urandom_range(9) < 7) begin
            send_file(1 << 20, $urandom_range(3));
            bytes_sent += file_bytes.size();
         end else if ($urandom_range(1)) begin
            send_file($urandom_range(file_bytes.size() - 1), 0);
            bytes_sent += file_bytes.size() / 2;
         end else begin
            repeat ($urandom_range(20, 1)) file_bytes[$urandom_range(file_bytes.size() - 1)] =
               8'($urandom_range(255));
            send_file(1 << 20, 1);
            bytes_sent += file_bytes.size();
         end
      end
      idle_on = 1'b1;
      hold_on = 1'b1;
      drain();
   endtask

   initial begin
      #2000000;
      $display("class_file_structure_parser_core: mismatch");
      $finish;
   end

   initial begin
      parser_clear();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_empty_structure();
      test_unknown_tag();
      test_wide_entries_last_slot();
      test_random_files();
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_words.size() == 0) begin
         $display("class_file_structure_parser_core: match");
      end else begin
         $display("class_file_structure_parser_core: mismatch");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/cfsp_pkg.sv
rtl/cfsp_walker.sv
rtl/cfsp_status.sv
rtl/class_file_structure_parser_core.sv
tb/sv/tb_class_file_structure_parser_core.sv
